[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/hpq_pkg.sv]
// Shared types and constants for the min-heap priority queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hpq_pkg;

  localparam int DEF_CAPACITY  = 64;
  localparam int DEF_VID_BITS  = 8;
  localparam int DIST_W        = 32;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_EXTRACT = 1'b1;

endpackage
`default_nettype wire

[rtl/hpq_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module hpq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/hpq_cmp.sv]
// Shared priority compare: a wins over b on smaller signed distance, then smaller id.
// Depends on hpq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hpq_cmp
  import hpq_pkg::*;
#(
  parameter int VERTEX_ID_BITS = DEF_VID_BITS
) (
  input  wire logic [VERTEX_ID_BITS+DIST_W-1:0] a,
  input  wire logic [VERTEX_ID_BITS+DIST_W-1:0] b,
  output logic                                  a_wins
);

  logic signed [DIST_W-1:0] a_dist, b_dist;
  logic [VERTEX_ID_BITS-1:0] a_vid, b_vid;

  assign a_dist = a[DIST_W-1:0];
  assign b_dist = b[DIST_W-1:0];
  assign a_vid  = a[VERTEX_ID_BITS+DIST_W-1:DIST_W];
  assign b_vid  = b[VERTEX_ID_BITS+DIST_W-1:DIST_W];

  always_comb begin
    if (a_dist != b_dist) begin
      a_wins = (a_dist < b_dist);
    end else begin
      a_wins = (a_vid < b_vid);
    end
  end

endmodule
`default_nettype wire

[rtl/min_heap_priority_queue.sv]
// Binary min-heap priority queue; one word per command, one result strobe per command.
// Full insert / empty extract: result in the cycle after start. Insert: each level the
// entry rises passes S_INS_CHK and S_INS_CMP, until it reaches the root or stops.
// Extract: S_X_ROOT, S_X_LAST, S_X_LOAD fetch root and last entry; per sift-down level
// S_X_CHK, S_X_LEFT, S_X_RIGHT, S_X_DEC (one heap RAM read per cycle, one shared
// compare); busy high meanwhile. Sync active-low reset empties the heap, RAM kept.
`timescale 1ns / 1ps
`default_nettype none
module min_heap_priority_queue
  import hpq_pkg::*;
#(
  parameter int CAPACITY       = DEF_CAPACITY,
  parameter int VERTEX_ID_BITS = DEF_VID_BITS
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_operation,
  input  wire logic [VERTEX_ID_BITS-1:0]       in_vertex_id,
  input  wire logic signed [DIST_W-1:0]        in_distance,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic [VERTEX_ID_BITS-1:0]            out_min_vertex_id,
  output logic signed [DIST_W-1:0]             out_min_distance,
  output logic [$clog2(CAPACITY+1)-1:0]        out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY+1);
  localparam int LW = AW + 2;
  localparam int EW = VERTEX_ID_BITS + DIST_W;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_INS_CHK = 10'b0000000010,
    S_INS_CMP = 10'b0000000100,
    S_X_ROOT  = 10'b0000001000,
    S_X_LAST  = 10'b0000010000,
    S_X_LOAD  = 10'b0000100000,
    S_X_CHK   = 10'b0001000000,
    S_X_LEFT  = 10'b0010000000,
    S_X_RIGHT = 10'b0100000000,
    S_X_DEC   = 10'b1000000000
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  hole_r, hole_nxt;
  logic [EW-1:0]  item_r, item_nxt;
  logic [EW-1:0]  best_r, best_nxt;
  logic [AW-1:0]  best_idx_r, best_idx_nxt;
  logic [EW-1:0]  top_r, top_nxt;

  logic                      out_valid_r;
  logic [1:0]                out_status_r;
  logic [VERTEX_ID_BITS-1:0] out_vid_r;
  logic [DIST_W-1:0]         out_dist_r;
  logic [CW-1:0]             out_count_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  logic [EW-1:0] cmp_a, cmp_b;
  logic          a_wins;

  logic          fin;
  status_t       fin_status;
  logic [EW-1:0] fin_entry;

  logic [AW-1:0] parent_idx;
  logic [LW-1:0] left_idx, right_idx, count_ext;

  assign parent_idx = (hole_r - AW'(1)) >> 1;
  assign left_idx   = LW'({hole_r, 1'b1});
  assign right_idx  = LW'({hole_r, 1'b0}) + LW'(2);
  assign count_ext  = LW'(count_r);

  hpq_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  hpq_cmp #(
    .VERTEX_ID_BITS(VERTEX_ID_BITS)
  ) u_cmp (
    .a     (cmp_a),
    .b     (cmp_b),
    .a_wins(a_wins)
  );

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    hole_nxt     = hole_r;
    item_nxt     = item_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    top_nxt      = top_r;
    ram_we       = 1'b0;
    ram_waddr    = hole_r;
    ram_wdata    = item_r;
    ram_raddr    = '0;
    cmp_a        = item_r;
    cmp_b        = ram_rdata;
    fin          = 1'b0;
    fin_status   = ST_OK;
    fin_entry    = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_operation == OP_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              fin        = 1'b1;
              fin_status = ST_FULL;
            end else begin
              item_nxt  = {in_vertex_id, in_distance};
              hole_nxt  = AW'(count_r);
              count_nxt = count_r + CW'(1);
              state_nxt = S_INS_CHK;
            end
          end else begin
            if (count_r == '0) begin
              fin        = 1'b1;
              fin_status = ST_EMPTY;
            end else begin
              state_nxt = S_X_ROOT;
            end
          end
        end
      end

      S_INS_CHK: begin
        if (hole_r == '0) begin
          ram_we    = 1'b1;
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = parent_idx;
          state_nxt = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        // item vs parent: move the parent down into the hole when the item wins
        ram_we = 1'b1;
        if (a_wins) begin
          ram_wdata = ram_rdata;
          hole_nxt  = parent_idx;
          state_nxt = S_INS_CHK;
        end else begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_X_ROOT: begin
        ram_raddr = '0;
        state_nxt = S_X_LAST;
      end

      S_X_LAST: begin
        top_nxt   = ram_rdata;
        count_nxt = count_r - CW'(1);
        ram_raddr = AW'(count_r - CW'(1));
        if (count_r == CW'(1)) begin
          fin       = 1'b1;
          fin_entry = ram_rdata;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_X_LOAD;
        end
      end

      S_X_LOAD: begin
        item_nxt  = ram_rdata;
        hole_nxt  = '0;
        state_nxt = S_X_CHK;
      end

      S_X_CHK: begin
        if (left_idx >= count_ext) begin
          ram_we    = 1'b1;
          fin       = 1'b1;
          fin_entry = top_r;
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = left_idx[AW-1:0];
          state_nxt = S_X_LEFT;
        end
      end

      S_X_LEFT: begin
        best_nxt     = ram_rdata;
        best_idx_nxt = left_idx[AW-1:0];
        if (right_idx < count_ext) begin
          ram_raddr = right_idx[AW-1:0];
          state_nxt = S_X_RIGHT;
        end else begin
          state_nxt = S_X_DEC;
        end
      end

      S_X_RIGHT: begin
        cmp_a = ram_rdata;
        cmp_b = best_r;
        if (a_wins) begin
          best_nxt     = ram_rdata;
          best_idx_nxt = right_idx[AW-1:0];
        end
        state_nxt = S_X_DEC;
      end

      S_X_DEC: begin
        // best child vs sinking item: pull the child up when it wins
        cmp_a  = best_r;
        cmp_b  = item_r;
        ram_we = 1'b1;
        if (a_wins) begin
          ram_wdata = best_r;
          hole_nxt  = best_idx_r;
          state_nxt = S_X_CHK;
        end else begin
          fin       = 1'b1;
          fin_entry = top_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    hole_r     <= hole_nxt;
    item_r     <= item_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    top_r      <= top_nxt;
    if (fin) begin
      out_status_r <= fin_status;
      out_vid_r    <= fin_entry[EW-1:DIST_W];
      out_dist_r   <= fin_entry[DIST_W-1:0];
      out_count_r  <= count_nxt;
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_min_vertex_id = out_vid_r;
  assign out_min_distance  = out_dist_r;
  assign out_entry_count   = out_count_r;

endmodule
`default_nettype wire

[rtl/hpq_checker.sv]
// Port-level checks for the min-heap priority queue, bound to the top level.
// Depends on hpq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hpq_checker
  import hpq_pkg::*;
#(
  parameter int CAPACITY       = DEF_CAPACITY,
  parameter int VERTEX_ID_BITS = DEF_VID_BITS
) (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            start,
  input wire logic                            busy,
  input wire logic                            in_operation,
  input wire logic [VERTEX_ID_BITS-1:0]       in_vertex_id,
  input wire logic signed [DIST_W-1:0]        in_distance,
  input wire logic                            out_valid,
  input wire logic [1:0]                      out_status,
  input wire logic [VERTEX_ID_BITS-1:0]       out_min_vertex_id,
  input wire logic signed [DIST_W-1:0]        out_min_distance,
  input wire logic [$clog2(CAPACITY+1)-1:0]   out_entry_count
);

  logic extract_word;
  logic zero_payload;

  assign extract_word = (in_operation == OP_EXTRACT) && (in_vertex_id == in_vertex_id)
                        && (in_distance == in_distance);
  assign zero_payload = (out_min_vertex_id == '0) && (out_min_distance == '0);

  `ASSERT_IMPLY(a_strobe_when_idle, clk, rst_n, out_valid, !busy)
  `ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || out_valid)
  `ASSERT_IMPLY(a_empty_count, clk, rst_n, out_valid && out_status == ST_EMPTY, out_entry_count == '0)
  `ASSERT_IMPLY(a_full_count, clk, rst_n, out_valid && out_status == ST_FULL, out_entry_count == ($clog2(CAPACITY+1))'(CAPACITY))
  `ASSERT_NEXT(a_insert_no_payload, clk, rst_n, start && !busy && !extract_word, busy || zero_payload)

endmodule

bind min_heap_priority_queue hpq_checker #(
  .CAPACITY      (CAPACITY),
  .VERTEX_ID_BITS(VERTEX_ID_BITS)
) u_hpq_checker (.*);
`default_nettype wire

[sim/min_heap_priority_queue_tb.sv]
// Self-checking testbench for the min-heap priority queue: directed and random
// insert/extract commands are checked against a software heap held in the bench.
// Depends on hpq_pkg and min_heap_priority_queue.
`timescale 1ns / 1ps
module min_heap_priority_queue_tb;
  import hpq_pkg::*;

  localparam int CAP     = DEF_CAPACITY;
  localparam int VID_W   = DEF_VID_BITS;
  localparam int COUNT_W = $clog2(DEF_CAPACITY + 1);
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_GAP = 32;

  typedef struct packed {
    status_t            status;
    logic [VID_W-1:0]   vid;
    logic [DIST_W-1:0]  dist_val;
    logic [COUNT_W-1:0] count;
  } heap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_operation = OP_INSERT;
  logic [VID_W-1:0] in_vertex_id = '0;
  logic signed [DIST_W-1:0] in_distance = '0;
  logic busy;
  logic out_valid;
  logic [1:0] out_status;
  logic [VID_W-1:0] out_min_vertex_id;
  logic signed [DIST_W-1:0] out_min_distance;
  logic [COUNT_W-1:0] out_entry_count;

  // software heap mirroring the block
  logic [VID_W-1:0]  heap_vid [CAP];
  logic [DIST_W-1:0] heap_dist [CAP];
  int heap_count = 0;

  heap_result_t pending_results[$];
  int idle_pct = 0;
  int error_count = 0;
  int words_sent = 0;
  int results_seen = 0;
  int extracted_seen = 0;
  int full_seen = 0;
  int empty_seen = 0;
  int peak_fill = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  min_heap_priority_queue dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_vertex_id      (in_vertex_id),
    .in_distance       (in_distance),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_min_vertex_id (out_min_vertex_id),
    .out_min_distance  (out_min_distance),
    .out_entry_count   (out_entry_count)
  );

  function automatic bit served_first(int a, int b);
    if (heap_dist[a] != heap_dist[b]) begin
      return $signed(heap_dist[a]) < $signed(heap_dist[b]);
    end
    return heap_vid[a] < heap_vid[b];
  endfunction

  function automatic void swap_entries(int a, int b);
    logic [VID_W-1:0] v;
    logic [DIST_W-1:0] d;
    v = heap_vid[a];
    d = heap_dist[a];
    heap_vid[a] = heap_vid[b];
    heap_dist[a] = heap_dist[b];
    heap_vid[b] = v;
    heap_dist[b] = d;
  endfunction

  // Apply one command to the software heap and return the result it produces.
  function automatic heap_result_t heap_apply(logic op, logic [VID_W-1:0] vid,
                                              logic [DIST_W-1:0] dist_val);
    heap_result_t res;
    int cur;
    int par;
    int lft;
    int rgt;
    int best;
    res.status = ST_OK;
    res.vid = '0;
    res.dist_val = '0;
    if (op == OP_INSERT) begin
      if (heap_count >= CAP) begin
        res.status = ST_FULL;
      end else begin
        cur = heap_count;
        heap_vid[cur] = vid;
        heap_dist[cur] = dist_val;
        heap_count++;
        while (cur > 0) begin
          par = (cur - 1) / 2;
          if (!served_first(cur, par)) break;
          swap_entries(cur, par);
          cur = par;
        end
      end
    end else if (heap_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.vid = heap_vid[0];
      res.dist_val = heap_dist[0];
      extracted_seen++;
      heap_count--;
      if (heap_count > 0) begin
        heap_vid[0] = heap_vid[heap_count];
        heap_dist[0] = heap_dist[heap_count];
        cur = 0;
        forever begin
          lft = 2 * cur + 1;
          rgt = 2 * cur + 2;
          best = cur;
          if (lft < heap_count && served_first(lft, best)) best = lft;
          if (rgt < heap_count && served_first(rgt, best)) best = rgt;
          if (best == cur) break;
          swap_entries(cur, best);
          cur = best;
        end
      end
    end
    res.count = heap_count[COUNT_W-1:0];
    if (heap_count > peak_fill) peak_fill = heap_count;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [DIST_W-1:0] got,
                                 logic [DIST_W-1:0] want);
    $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h at %0t",
             results_seen, what, got, want, $realtime);
    error_count++;
  endtask

  // Hold the word until the block takes it, then record what it must produce.
  task automatic send_word(logic op, logic [VID_W-1:0] vid, logic [DIST_W-1:0] dist_val);
    start <= 1'b1;
    in_operation <= op;
    in_vertex_id <= vid;
    in_distance <= dist_val;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(heap_apply(op, vid, dist_val));
    words_sent++;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
  endtask

  task automatic insert_entry(logic [VID_W-1:0] vid, logic [DIST_W-1:0] dist_val);
    send_word(OP_INSERT, vid, dist_val);
  endtask

  // Extract ignores the payload: drive noise on it.
  task automatic extract_min();
    send_word(OP_EXTRACT, VID_W'($urandom), $urandom);
  endtask

  // Drop start and hold off until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [DIST_W-1:0] pick_distance();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3, 4: return DIST_W'($signed($urandom_range(8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VID_W-1:0] pick_vertex();
    if ($urandom_range(3) == 0) return VID_W'($urandom_range(3));
    return VID_W'($urandom);
  endfunction

  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (out_status == ST_FULL) full_seen++;
      if (out_status == ST_EMPTY) empty_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, status", DIST_W'(out_status), '0);
      end else begin
        want = pending_results.pop_front();
        if (out_status != want.status)
          report_mismatch("status", DIST_W'(out_status), DIST_W'(want.status));
        if (out_min_vertex_id != want.vid)
          report_mismatch("min_vertex_id", DIST_W'(out_min_vertex_id), DIST_W'(want.vid));
        if (out_min_distance != want.dist_val)
          report_mismatch("min_distance", out_min_distance, want.dist_val);
        if (out_entry_count != want.count)
          report_mismatch("entry_count", DIST_W'(out_entry_count), DIST_W'(want.count));
      end
    end
  end

  task automatic test_empty_heap();
    extract_min();
    extract_min();
    drain_results();
  endtask

  task automatic test_key_extremes();
    insert_entry(8'd255, 32'h7fff_ffff);
    insert_entry(8'd0, 32'h8000_0000);
    insert_entry(8'd170, 32'h0000_0000);
    insert_entry(8'd85, 32'hffff_ffff);
    insert_entry(8'd1, 32'h5555_5555);
    insert_entry(8'd254, 32'haaaa_aaaa);
    repeat (7) extract_min();
    drain_results();
  endtask

  task automatic test_tie_break();
    insert_entry(8'd255, 32'd7);
    insert_entry(8'd0, 32'd7);
    insert_entry(8'd128, 32'd7);
    insert_entry(8'd3, 32'hffff_fff9);
    insert_entry(8'd2, 32'hffff_fff9);
    repeat (5) extract_min();
    drain_results();
  endtask

  // Fill to capacity, push past it, then empty it and extract once more.
  task automatic test_full_heap();
    while (heap_count < CAP) insert_entry(pick_vertex(), pick_distance());
    insert_entry(pick_vertex(), pick_distance());
    insert_entry(pick_vertex(), pick_distance());
    repeat (CAP + 1) extract_min();
  endtask

  task automatic test_random_mix(int n_words);
    int insert_pct;
    for (int i = 0; i < n_words; i++) begin
      if (heap_count < 8) insert_pct = 70;
      else if (heap_count > CAP - 8) insert_pct = 30;
      else insert_pct = 50;
      if ($urandom_range(99) < insert_pct) insert_entry(pick_vertex(), pick_distance());
      else extract_min();
    end
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_heap();
    test_key_extremes();
    test_tie_break();

    idle_pct = 0;
    test_full_heap();
    test_random_mix(130);
    drain_results();

    idle_pct = 57;
    test_random_mix(130);
    test_full_heap();
    drain_results();

    idle_pct = 7;
    test_random_mix(130);
    drain_results();

    repeat (40) @(posedge clk);
    $display("Covered %0d commands: %0d entries extracted, %0d full-heap inserts, %0d empty extracts",
             words_sent, extracted_seen, full_seen, empty_seen);
    $display("Peak fill %0d of %0d entries, sender idle ratios 0, 57 and 7 percent",
             peak_fill, CAP);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/hpq_pkg.sv
rtl/hpq_ram.sv
rtl/hpq_cmp.sv
rtl/min_heap_priority_queue.sv
rtl/hpq_checker.sv
sim/min_heap_priority_queue_tb.sv
